[rtl/faa_pkg.sv]
package faa_pkg;

    localparam int IDX_W      = 16;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 12;
    localparam int NUM_CH     = 3;
    localparam int CNT_W      = 5;
    localparam int REM_W      = CNT_W - 1;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = 4;

    // Lane order inside a packed sum word and a packed pixel.
    localparam int CH_RED     = 2;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 0;

    localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [PIX_W-1:0] AVG_MAX    = {PIX_W{1'b1}};
    localparam logic [CNT_W-1:0] MAX_IMAGES = CNT_W'(16);
    localparam logic [CNT_W-1:0] COUNT_RST  = CNT_W'(1);

    localparam logic OP_ACC = 1'b0;
    localparam logic OP_AVG = 1'b1;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;
    typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_write;
        logic capture;
        logic acc_write;
        logic avg_start;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic op_avg;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

[rtl/faa_div.sv]
module faa_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [faa_pkg::CNT_W-1:0] divisor,
    input  faa_pkg::sums_t          dividend,
    output faa_pkg::sums_t          quotient,
    output logic                    done
);

    // Three restoring dividers in lockstep, one quotient bit per cycle.
    faa_pkg::sums_t                                    dvd_reg, dvd_next;
    logic [faa_pkg::NUM_CH-1:0][faa_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [faa_pkg::CNT_W-1:0]                         dsr_reg;
    logic [faa_pkg::STEP_W-1:0]                        step_reg;
    logic                                              busy_reg;
    logic                                              done_reg;

    always_comb begin
        logic [faa_pkg::CNT_W-1:0] rem_shift;
        logic [faa_pkg::CNT_W-1:0] rem_diff;
        for (int c = 0; c < faa_pkg::NUM_CH; c++) begin
            rem_shift = {rem_reg[c], dvd_reg[c][faa_pkg::SUM_W-1]};
            rem_diff  = rem_shift - dsr_reg;
            if (rem_shift >= dsr_reg) begin
                rem_next[c] = rem_diff[faa_pkg::REM_W-1:0];
                dvd_next[c] = {dvd_reg[c][faa_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_next[c] = rem_shift[faa_pkg::REM_W-1:0];
                dvd_next[c] = {dvd_reg[c][faa_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == faa_pkg::STEP_W'(faa_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

[rtl/faa_datapath.sv]
module faa_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  faa_pkg::cmd_t               cmd,
    output faa_pkg::sts_t               sts,
    input  logic                        cfg_wr_en,
    input  logic [faa_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        s_opcode,
    input  logic [faa_pkg::IDX_W-1:0]   s_pixel_index,
    input  logic [faa_pkg::PIX_W-1:0]   s_red_in,
    input  logic [faa_pkg::PIX_W-1:0]   s_green_in,
    input  logic [faa_pkg::PIX_W-1:0]   s_blue_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [faa_pkg::IDX_W-1:0]   m_pixel_out_index,
    output logic [faa_pkg::PIX_W-1:0]   m_red_avg,
    output logic [faa_pkg::PIX_W-1:0]   m_green_avg,
    output logic [faa_pkg::PIX_W-1:0]   m_blue_avg
);

    faa_pkg::sums_t                   sum_mem [2**faa_pkg::IDX_W];
    faa_pkg::sums_t                   rd_data_reg;
    faa_pkg::sums_t                   wr_data;
    logic [faa_pkg::IDX_W-1:0]        wr_addr;
    logic                             wr_en;

    logic [faa_pkg::IDX_W-1:0]        clr_addr_reg;
    logic [faa_pkg::CNT_W-1:0]        count_reg;
    logic [faa_pkg::CNT_W-1:0]        divisor;

    logic                             op_reg;
    logic [faa_pkg::IDX_W-1:0]        idx_reg;
    faa_pkg::pix_t                    pix_reg;
    faa_pkg::sums_t                   acc_sums;

    faa_pkg::sums_t                   quotient;
    logic                             div_done;
    faa_pkg::pix_t                    avg;

    logic                             m_valid_reg;
    logic [faa_pkg::IDX_W-1:0]        m_index_reg;
    faa_pkg::pix_t                    m_avg_reg;

    // Sum store: one write port, one registered read port.
    always_comb begin
        wr_en   = cmd.clr_write | cmd.acc_write | cmd.avg_start;
        wr_addr = cmd.clr_write ? clr_addr_reg : idx_reg;
        wr_data = cmd.acc_write ? acc_sums : '0;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sum_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= sum_mem[s_pixel_index];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_write) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= faa_pkg::COUNT_RST;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (count_reg == '0) begin
            divisor = faa_pkg::CNT_W'(1);
        end else if (count_reg > faa_pkg::MAX_IMAGES) begin
            divisor = faa_pkg::MAX_IMAGES;
        end else begin
            divisor = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg                    <= s_opcode;
            idx_reg                   <= s_pixel_index;
            pix_reg[faa_pkg::CH_RED]   <= s_red_in;
            pix_reg[faa_pkg::CH_GREEN] <= s_green_in;
            pix_reg[faa_pkg::CH_BLUE]  <= s_blue_in;
        end
    end

    // Saturating accumulate of each channel.
    always_comb begin
        logic [faa_pkg::SUM_W:0] wide;
        for (int c = 0; c < faa_pkg::NUM_CH; c++) begin
            wide = {1'b0, rd_data_reg[c]}
                 + {{(faa_pkg::SUM_W - faa_pkg::PIX_W + 1){1'b0}}, pix_reg[c]};
            acc_sums[c] = wide[faa_pkg::SUM_W] ? faa_pkg::SUM_MAX
                                               : wide[faa_pkg::SUM_W-1:0];
        end
    end

    faa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.avg_start),
        .divisor  (divisor),
        .dividend (rd_data_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb begin
        for (int c = 0; c < faa_pkg::NUM_CH; c++) begin
            if (quotient[c] > faa_pkg::SUM_W'(faa_pkg::AVG_MAX)) begin
                avg[c] = faa_pkg::AVG_MAX;
            end else begin
                avg[c] = quotient[c][faa_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_index_reg <= idx_reg;
            m_avg_reg   <= avg;
        end
    end

    always_comb begin
        sts.clr_done = (clr_addr_reg == {faa_pkg::IDX_W{1'b1}});
        sts.op_avg   = (op_reg == faa_pkg::OP_AVG);
        sts.div_done = div_done;
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid           = m_valid_reg;
    assign m_pixel_out_index = m_index_reg;
    assign m_red_avg         = m_avg_reg[faa_pkg::CH_RED];
    assign m_green_avg       = m_avg_reg[faa_pkg::CH_GREEN];
    assign m_blue_avg        = m_avg_reg[faa_pkg::CH_BLUE];

endmodule

[rtl/faa_ctrl.sv]
module faa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  faa_pkg::sts_t  sts,
    output faa_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                if (sts.op_avg) begin
                    cmd.avg_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    cmd.acc_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        s_ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

[rtl/frame_average_accumulator_core.sv]
// Per-pixel frame averaging core. Each transaction on the s_ channel either adds one RGB pixel
// into that pixel's 12-bit-per-channel sum (opcode 0, no result) or reads the sums, divides
// each channel by image_count and returns the average on the m_ channel while clearing the
// entry (opcode 1). Sums saturate at 4095, averages at 255; an image_count of 0 acts as 1 and
// values above 16 act as 16. After reset the core sweeps the 65536-entry sum memory to zero,
// one entry per cycle, and holds s_ready low during the sweep; configuration writes are
// taken during the sweep. Items are processed one at a time: an accumulate goes through a
// registered memory read, then the write back, before the next item can be accepted, and an
// average goes through the memory read, the divider start, the bit-serial divider, a state
// that sees the divider finish, and the output load that puts its result on m_valid. An
// average takes longer only if the previous result is still waiting on m_ready. The output
// register lets the next item be accepted while a result is waiting.
module frame_average_accumulator_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [faa_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [faa_pkg::IDX_W-1:0]   s_pixel_index,
    input  logic [faa_pkg::PIX_W-1:0]   s_red_in,
    input  logic [faa_pkg::PIX_W-1:0]   s_green_in,
    input  logic [faa_pkg::PIX_W-1:0]   s_blue_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [faa_pkg::IDX_W-1:0]   m_pixel_out_index,
    output logic [faa_pkg::PIX_W-1:0]   m_red_avg,
    output logic [faa_pkg::PIX_W-1:0]   m_green_avg,
    output logic [faa_pkg::PIX_W-1:0]   m_blue_avg
);

    // Command and status groups between the controller and the datapath.
    faa_pkg::cmd_t cmd;
    faa_pkg::sts_t sts;

    faa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath owns the sum memory, the clearing counter, the image count register,
    // the divider and the output register.
    faa_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_opcode          (s_opcode),
        .s_pixel_index     (s_pixel_index),
        .s_red_in          (s_red_in),
        .s_green_in        (s_green_in),
        .s_blue_in         (s_blue_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pixel_out_index (m_pixel_out_index),
        .m_red_avg         (m_red_avg),
        .m_green_avg       (m_green_avg),
        .m_blue_avg        (m_blue_avg)
    );

    // Only one transaction is in flight: acceptance drops s_ready on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while one is in flight");

    // Every accepted transaction is captured by the datapath.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> cmd.capture)
        else $error("accepted transaction not captured");

    // A result only appears after the controller loaded the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result appeared without an output load");

    // A waiting result is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten before it was taken");

endmodule

[sim/tb_frame_average_accumulator_core.sv]
`timescale 1ns / 1ps

module tb_frame_average_accumulator_core;

    // The sum store covers every value of the 16-bit pixel index.
    localparam int NUM_PIXELS    = 1 << faa_pkg::IDX_W;
    localparam int ITEM_TARGET   = 850;
    // The core clears its 65536-entry sum memory after reset with s_ready low,
    // so the watchdog limit has to sit well above that sweep.
    localparam int STALL_LIMIT   = 200000;
    // An average still has to pass the divider before it reaches the output register, and
    // an accumulate that produces no result may still be writing back after the
    // last result has come out. This many quiet cycles covers both.
    localparam int SETTLE_CYCLES = 24;

    // One averaged pixel as it is expected on the m_ channel.
    typedef struct packed {
        logic [faa_pkg::IDX_W-1:0] index;
        logic [faa_pkg::PIX_W-1:0] red;
        logic [faa_pkg::PIX_W-1:0] green;
        logic [faa_pkg::PIX_W-1:0] blue;
    } avg_pixel_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [faa_pkg::CNT_W-1:0] cfg_wr_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_opcode;
    logic [faa_pkg::IDX_W-1:0] s_pixel_index;
    logic [faa_pkg::PIX_W-1:0] s_red_in;
    logic [faa_pkg::PIX_W-1:0] s_green_in;
    logic [faa_pkg::PIX_W-1:0] s_blue_in;
    logic                      m_valid;
    logic                      m_ready;
    logic [faa_pkg::IDX_W-1:0] m_pixel_out_index;
    logic [faa_pkg::PIX_W-1:0] m_red_avg;
    logic [faa_pkg::PIX_W-1:0] m_green_avg;
    logic [faa_pkg::PIX_W-1:0] m_blue_avg;

    // Shadow copy of the per-pixel channel sums and of the image count register.
    faa_pkg::sums_t            pixel_sums [NUM_PIXELS];
    logic [faa_pkg::CNT_W-1:0] image_count_q;

    // Averages that the core owes us, oldest first.
    avg_pixel_t       pending_avgs [$];

    int error_count = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    // When set, neither the sender nor the receiver inserts any idle cycles.
    bit quiet = 1'b0;

    frame_average_accumulator_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_pixel_index     (s_pixel_index),
        .s_red_in          (s_red_in),
        .s_green_in        (s_green_in),
        .s_blue_in         (s_blue_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pixel_out_index (m_pixel_out_index),
        .m_red_avg         (m_red_avg),
        .m_green_avg       (m_green_avg),
        .m_blue_avg        (m_blue_avg)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Adds one 8-bit channel value into a 12-bit sum, clamping at the top instead
    // of wrapping around.
    function automatic logic [faa_pkg::SUM_W-1:0] add_clamped(
        input logic [faa_pkg::SUM_W-1:0] sum,
        input logic [faa_pkg::PIX_W-1:0] pix);
        logic [faa_pkg::SUM_W:0] total;
        total = {1'b0, sum} + pix;
        return (total > faa_pkg::SUM_MAX) ? faa_pkg::SUM_MAX : total[faa_pkg::SUM_W-1:0];
    endfunction

    // Divisor the core really uses: a count of zero acts as one, and anything above
    // the frame limit acts as the limit.
    function automatic logic [faa_pkg::CNT_W-1:0] divisor_of(
        input logic [faa_pkg::CNT_W-1:0] cnt);
        if (cnt == '0) begin
            return faa_pkg::CNT_W'(1);
        end
        return (cnt > faa_pkg::MAX_IMAGES) ? faa_pkg::MAX_IMAGES : cnt;
    endfunction

    // Truncating channel average, clamped to the pixel range. The clamp matters when
    // more frames were summed than the divisor says.
    function automatic logic [faa_pkg::PIX_W-1:0] channel_mean(
        input logic [faa_pkg::SUM_W-1:0] sum,
        input logic [faa_pkg::CNT_W-1:0] cnt);
        logic [faa_pkg::SUM_W-1:0] quotient;
        quotient = sum / divisor_of(cnt);
        return (quotient > faa_pkg::AVG_MAX) ? faa_pkg::AVG_MAX
                                             : quotient[faa_pkg::PIX_W-1:0];
    endfunction

    // Updates the shadow sums for one accepted transaction and, for an average,
    // queues the pixel that the core must return and clears the entry.
    function automatic void apply_transaction(input logic op,
                                              input logic [faa_pkg::IDX_W-1:0] idx,
                                              input logic [faa_pkg::PIX_W-1:0] r, g, b);
        avg_pixel_t res;
        if (op == faa_pkg::OP_ACC) begin
            pixel_sums[idx][faa_pkg::CH_RED]   =
                add_clamped(pixel_sums[idx][faa_pkg::CH_RED], r);
            pixel_sums[idx][faa_pkg::CH_GREEN] =
                add_clamped(pixel_sums[idx][faa_pkg::CH_GREEN], g);
            pixel_sums[idx][faa_pkg::CH_BLUE]  =
                add_clamped(pixel_sums[idx][faa_pkg::CH_BLUE], b);
        end else begin
            res.index = idx;
            res.red   = channel_mean(pixel_sums[idx][faa_pkg::CH_RED], image_count_q);
            res.green = channel_mean(pixel_sums[idx][faa_pkg::CH_GREEN], image_count_q);
            res.blue  = channel_mean(pixel_sums[idx][faa_pkg::CH_BLUE], image_count_q);
            pending_avgs = {pending_avgs, res};
            pixel_sums[idx] = '0;
        end
    endfunction

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Half of the indexes come from a small corner so that unrelated traffic keeps
    // landing on the same entries; the rest spread over the full index range.
    function automatic logic [faa_pkg::IDX_W-1:0] pick_index();
        if ($urandom_range(0, 1) == 0) begin
            return faa_pkg::IDX_W'($urandom_range(0, 15));
        end
        return faa_pkg::IDX_W'($urandom_range(0, NUM_PIXELS - 1));
    endfunction

    // Channel values lean toward the extremes so that clamping shows up often.
    function automatic logic [faa_pkg::PIX_W-1:0] pick_channel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return faa_pkg::AVG_MAX;
        end
        return faa_pkg::PIX_W'($urandom_range(0, 255));
    endfunction

    // Sends one transaction on the s_ channel. Valid is left high on return so that
    // the next call can follow without a bubble; it is only lowered at the start of
    // a gap or by drain_results.
    task automatic send_pixel(input logic op, input logic [faa_pkg::IDX_W-1:0] idx,
                              input logic [faa_pkg::PIX_W-1:0] r, g, b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_pixel_index <= idx;
        s_red_in      <= r;
        s_green_in    <= g;
        s_blue_in     <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_transaction(op, idx, r, g, b);
        items_sent++;
    endtask

    // Holds off the sender until every owed average has come back, then lets the
    // core finish any trailing accumulate before anything else happens.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_avgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The image count register is only written while the core has nothing in flight.
    task automatic set_image_count(input logic [faa_pkg::CNT_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        image_count_q  = value;
    endtask

    // With the reset count of one: an all-zero pixel and an all-ones pixel at the
    // two ends of the index range, plus an average of an entry nobody touched.
    task automatic test_basic_extremes();
        send_pixel(faa_pkg::OP_ACC, '0, '0, '0, '0);
        send_pixel(faa_pkg::OP_ACC, '1, '1, '1, '1);
        send_pixel(faa_pkg::OP_AVG, '0, '1, '1, '1);
        send_pixel(faa_pkg::OP_AVG, '1, '0, '0, '0);
        send_pixel(faa_pkg::OP_AVG, 16'hAAAA, 8'h55, 8'hAA, 8'h0F);
    endtask

    // A count of zero must divide by one, which also drives averages past 255 when
    // two frames land in the same entry. A count above the frame limit divides by
    // the limit.
    task automatic test_divisor_limits();
        set_image_count(faa_pkg::CNT_W'(0));
        send_pixel(faa_pkg::OP_ACC, 16'h00FF, 8'd200, 8'd1, 8'd128);
        send_pixel(faa_pkg::OP_ACC, 16'h00FF, 8'd200, 8'd1, 8'd128);
        send_pixel(faa_pkg::OP_AVG, 16'h00FF, '0, '0, '0);
        set_image_count('1);
        send_pixel(faa_pkg::OP_ACC, 16'h0F0F, 8'd160, 8'd17, 8'd255);
        send_pixel(faa_pkg::OP_AVG, 16'h0F0F, '0, '0, '0);
    endtask

    // Seventeen full-scale frames push the red sum past its 12-bit ceiling while
    // green and blue stay in range.
    task automatic test_sum_saturation();
        set_image_count(faa_pkg::MAX_IMAGES);
        repeat (17) send_pixel(faa_pkg::OP_ACC, 16'hF0F0, 8'd255, 8'd128, 8'd1);
        send_pixel(faa_pkg::OP_AVG, 16'hF0F0, '0, '0, '0);
    endtask

    // Composites built the way a frame source would: pick a count, stream a number
    // of frames over a small set of pixels, then read each pixel back. Most of the
    // time the frame count matches the divisor; otherwise it falls short, runs over past
    // the frame limit, or is zero. Stray transactions are mixed in, and some of them
    // average a pixel in the middle of its composite.
    task automatic test_random_composites();
        logic [faa_pkg::IDX_W-1:0] pool [$];
        logic [faa_pkg::CNT_W-1:0] count;
        int                        roll;
        int                        frames;
        int                        div;
        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                count = faa_pkg::CNT_W'(0);
            end else if (roll < 16) begin
                count = faa_pkg::CNT_W'($urandom_range(17, 31));
            end else if (roll < 26) begin
                count = faa_pkg::CNT_W'(1);
            end else if (roll < 36) begin
                count = faa_pkg::MAX_IMAGES;
            end else begin
                count = faa_pkg::CNT_W'($urandom_range(1, 16));
            end
            set_image_count(count);
            quiet = ($urandom_range(0, 3) == 0);

            pool.delete();
            repeat ($urandom_range(1, 6)) pool = {pool, pick_index()};

            div  = divisor_of(count);
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                frames = div;
            end else if (roll < 80) begin
                frames = $urandom_range(1, div + 3);
            end else if (roll < 92) begin
                frames = $urandom_range(17, 20);
            end else begin
                frames = 0;
            end

            repeat (frames) begin
                foreach (pool[k]) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_pixel(1'($urandom_range(0, 1)), pick_index(),
                                   pick_channel(), pick_channel(), pick_channel());
                    end
                    send_pixel(faa_pkg::OP_ACC, pool[k], pick_channel(), pick_channel(),
                               pick_channel());
                end
            end
            foreach (pool[k]) begin
                send_pixel(faa_pkg::OP_AVG, pool[k], pick_channel(), pick_channel(),
                           pick_channel());
            end
        end
        quiet = 1'b0;
    endtask

    // Result side: m_ready drops for random stretches, mostly short, sometimes long,
    // and stays high throughout the quiet phases.
    initial begin : result_sink
        int run;
        int hold;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                run  = $urandom_range(1, 12);
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Every result transaction is matched against the oldest owed average.
    always @(posedge aclk) begin : result_check
        avg_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_avgs.size() == 0) begin
                $display("%0t: result with nothing owed, expected none, actual index %0d",
                         $time, m_pixel_out_index);
                error_count++;
            end else begin
                want = pending_avgs.pop_front();
                check_field("pixel_out_index", want.index, m_pixel_out_index);
                check_field("red_avg", want.red, m_red_avg);
                check_field("green_avg", want.green, m_green_avg);
                check_field("blue_avg", want.blue, m_blue_avg);
            end
        end
    end

    // Ends the run if neither channel completes a transaction for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= faa_pkg::COUNT_RST;
        s_valid       <= 1'b0;
        s_opcode      <= faa_pkg::OP_ACC;
        s_pixel_index <= '0;
        s_red_in      <= '0;
        s_green_in    <= '0;
        s_blue_in     <= '0;
        foreach (pixel_sums[i]) pixel_sums[i] = '0;
        image_count_q = faa_pkg::COUNT_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_extremes();
        test_divisor_limits();
        test_sum_saturation();
        test_random_composites();

        drain_results();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
